/* src/psm_pkg.sv */
package psm_pkg;

    localparam int STACK_DEPTH_DEF   = 1024;
    localparam int DISPLAY_DEPTH_DEF = 16;
    localparam int PROGRAM_SIZE      = 4096;
    localparam int PC_W              = $clog2(PROGRAM_SIZE);
    localparam int DATA_W            = 64;
    localparam int NUM_W             = 10;
    localparam int CMD_W             = 5;
    localparam int OPND_W            = 32;

    typedef enum logic [CMD_W-1:0] {
        OP_INPP = 5'd0,  OP_CRCT = 5'd1,  OP_SOMA = 5'd2,  OP_SUBT = 5'd3,
        OP_DIVI = 5'd4,  OP_MULT = 5'd5,  OP_INVR = 5'd6,  OP_NEGA = 5'd7,
        OP_CONJ = 5'd8,  OP_DISJ = 5'd9,  OP_CMME = 5'd10, OP_CMMA = 5'd11,
        OP_CMIG = 5'd12, OP_CMDG = 5'd13, OP_CMAG = 5'd14, OP_CMEG = 5'd15,
        OP_DSVF = 5'd16, OP_DSVS = 5'd17, OP_AMEM = 5'd18, OP_DMEM = 5'd19,
        OP_CRVL = 5'd20, OP_ARMZ = 5'd21, OP_IMPR = 5'd22, OP_LEIT = 5'd23,
        OP_ARMI = 5'd24, OP_CHPR = 5'd25, OP_CREN = 5'd26, OP_ENPR = 5'd27,
        OP_ENRT = 5'd28, OP_RTPR = 5'd29
    } t_op;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_DIV0   = 2'd1,
        FLT_RANGE  = 2'd2,
        FLT_OPCODE = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        S_IDLE, S_RDA, S_RDB, S_CAPB, S_EXE, S_MD, S_WR2, S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

endpackage

/* src/pascal_stack_machine_executor_core.sv */
// Executes one stack machine instruction per input beat and returns one result beat with
// the next pc, an optional printed value and a fault code. The stack lives in a synchronous
// single-read, single-write memory; the display of frame bases, stack top and pc are flops.
// One instruction is taken at a time: a plain instruction passes from input beat to result
// beat through two stack reads, execute and write, and the result register; a call adds a
// second write state since it writes two cells, and multiply or divide wait on the bit-serial
// multiply/divide unit. A faulting instruction changes no state and returns the current pc;
// one caught by the opcode or range check goes to the result register without the stack
// reads. The input side is free again as soon as a result sits in the output register.
module pascal_stack_machine_executor_core #(
    parameter int STACK_DEPTH   = psm_pkg::STACK_DEPTH_DEF,
    parameter int DISPLAY_DEPTH = psm_pkg::DISPLAY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [psm_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [psm_pkg::OPND_W-1:0]   i_first_operand,
    input  logic [psm_pkg::NUM_W-1:0]           i_second_operand,
    input  logic signed [psm_pkg::OPND_W-1:0]   i_read_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [psm_pkg::PC_W-1:0]            o_next_pc,
    output logic                                o_print_valid,
    output logic signed [psm_pkg::DATA_W-1:0]   o_print_value,
    output logic [1:0]                          o_fault
);
    import psm_pkg::*;

    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int BW  = SW + 1;
    localparam int DXW = $clog2(DISPLAY_DEPTH);
    localparam int CW  = ((SW > NUM_W) ? SW : NUM_W) + 3;
    localparam logic signed [CW-1:0] SDC = CW'(STACK_DEPTH);

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [OPND_W-1:0]   r_k;
    logic [NUM_W-1:0]    r_n;
    logic [OPND_W-1:0]   r_rd;
    logic signed [SW:0]  r_sp;
    logic [PC_W-1:0]     r_pc;
    logic [BW-1:0]       r_disp [DISPLAY_DEPTH];
    logic [DATA_W-1:0]   r_a;
    logic [DATA_W-1:0]   r_b;
    logic [SW-1:0]       r_w2_addr;
    logic [DATA_W-1:0]   r_w2_data;
    logic [PC_W-1:0]     r_res_pc;
    logic                r_res_pv;
    logic [DATA_W-1:0]   r_res_pval;
    t_fault              r_res_fault;
    logic                r_out_valid;
    logic [PC_W-1:0]     r_out_pc;
    logic                r_out_pv;
    logic [DATA_W-1:0]   r_out_pval;
    t_fault              r_out_fault;

    t_op                 op;
    logic signed [CW-1:0] sp_c, n_c, base_c, addr_c, sp1, sp2, spm1, spm2, sp_ret;
    logic [PC_W-1:0]     pc1, tgt;
    logic                lvl_ok;
    logic [DXW-1:0]      lvl_idx;
    logic                rf, bad;
    logic signed [CW-1:0] ra, rb;

    logic                ex_commit;
    t_fault              ex_fault;
    logic                we0;
    logic signed [CW-1:0] wa0;
    logic [DATA_W-1:0]   wd0;
    logic signed [CW-1:0] sp_new;
    logic [PC_W-1:0]     pc_new;
    logic                pv;
    logic [DATA_W-1:0]   pval;
    logic                disp_we;
    logic [DXW-1:0]      disp_idx;
    logic [BW-1:0]       disp_val;
    logic                need_md;
    logic                wr2;

    t_md_req             md_req;
    logic                md_done;
    logic [DATA_W-1:0]   md_res;
    logic                ram_we;
    logic [SW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [SW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                out_load;

    function automatic logic in_stk(input logic signed [CW-1:0] x);
        return (x >= 0) && (x < SDC);
    endfunction

    assign op      = t_op'(r_cmd);
    assign sp_c    = CW'(r_sp);
    assign n_c     = signed'(CW'(r_n));
    assign lvl_ok  = !r_k[OPND_W-1] && (r_k < OPND_W'(DISPLAY_DEPTH));
    assign lvl_idx = r_k[DXW-1:0];
    assign base_c  = lvl_ok ? signed'(CW'(r_disp[lvl_idx])) : '0;
    assign addr_c  = base_c + n_c;
    assign sp1     = sp_c + CW'(1);
    assign sp2     = sp_c + CW'(2);
    assign spm1    = sp_c - CW'(1);
    assign spm2    = sp_c - CW'(2);
    assign sp_ret  = sp_c - n_c - CW'(3);
    assign pc1     = r_pc + 1'b1;
    assign tgt     = r_k[PC_W-1:0];

    // range checks and read addresses
    always_comb begin
        rf  = 1'b0;
        bad = 1'b0;
        ra  = spm1;
        rb  = sp_c;
        unique case (op) inside
            OP_INPP, OP_DSVS: ;
            OP_CRCT, OP_LEIT: rf = !in_stk(sp1);
            OP_SOMA, OP_SUBT, OP_DIVI, OP_MULT, OP_CONJ, OP_DISJ,
            OP_CMME, OP_CMMA, OP_CMIG, OP_CMDG, OP_CMAG, OP_CMEG:
                rf = (sp_c < CW'(1)) || !in_stk(sp_c);
            OP_INVR, OP_NEGA, OP_DSVF, OP_IMPR: rf = !in_stk(sp_c);
            OP_AMEM: rf = (sp_c + n_c) > (SDC - CW'(1));
            OP_DMEM: rf = (sp_c - n_c) < -CW'(1);
            OP_CRVL: begin
                rf = !lvl_ok || !in_stk(addr_c) || !in_stk(sp1);
                rb = addr_c;
            end
            OP_ARMZ: rf = !lvl_ok || !in_stk(addr_c) || !in_stk(sp_c);
            OP_ARMI: begin
                rf = !lvl_ok || !in_stk(addr_c) || !in_stk(sp_c);
                ra = sp_c;
                rb = addr_c;
            end
            OP_CHPR: rf = sp2 > (SDC - CW'(1));
            OP_CREN, OP_ENPR: rf = !lvl_ok || !in_stk(sp1);
            OP_ENRT: rf = !lvl_ok || (addr_c < 0) || (addr_c > SDC);
            OP_RTPR: begin
                rf = !lvl_ok || (sp_c < CW'(2)) || !in_stk(sp_c) || (sp_ret < -CW'(1));
                ra = spm2;
            end
            default: bad = 1'b1;
        endcase
    end

    // execute on the two operands read from the stack
    always_comb begin
        ex_fault = FLT_NONE;
        we0      = 1'b0;
        wa0      = spm1;
        wd0      = '0;
        sp_new   = sp_c;
        pc_new   = pc1;
        pv       = 1'b0;
        pval     = '0;
        disp_we  = 1'b0;
        disp_idx = lvl_idx;
        disp_val = '0;
        need_md  = 1'b0;
        wr2      = 1'b0;
        case (op) inside
            OP_INPP: begin
                sp_new   = -CW'(1);
                disp_we  = 1'b1;
                disp_idx = '0;
            end
            OP_CRCT, OP_LEIT: begin
                we0    = 1'b1;
                wa0    = sp1;
                wd0    = (op == OP_CRCT) ? {{(DATA_W-OPND_W){r_k[OPND_W-1]}}, r_k}
                                         : {{(DATA_W-OPND_W){r_rd[OPND_W-1]}}, r_rd};
                sp_new = sp1;
            end
            OP_SOMA, OP_SUBT, OP_DIVI, OP_MULT, OP_CONJ, OP_DISJ,
            OP_CMME, OP_CMMA, OP_CMIG, OP_CMDG, OP_CMAG, OP_CMEG: begin
                we0    = 1'b1;
                sp_new = spm1;
                case (op) inside
                    OP_SOMA: wd0 = r_a + r_b;
                    OP_SUBT: wd0 = r_a - r_b;
                    OP_DIVI: begin
                        if (r_b == '0) begin
                            ex_fault = FLT_DIV0;
                        end else begin
                            need_md = 1'b1;
                        end
                    end
                    OP_MULT: need_md = 1'b1;
                    OP_CONJ: wd0 = DATA_W'((r_a == DATA_W'(1)) && (r_b == DATA_W'(1)));
                    OP_DISJ: wd0 = DATA_W'((r_a == DATA_W'(1)) || (r_b == DATA_W'(1)));
                    OP_CMME: wd0 = DATA_W'($signed(r_a) < $signed(r_b));
                    OP_CMMA: wd0 = DATA_W'($signed(r_b) < $signed(r_a));
                    OP_CMIG: wd0 = DATA_W'(r_a == r_b);
                    OP_CMDG: wd0 = DATA_W'(r_a != r_b);
                    OP_CMAG: wd0 = DATA_W'(!($signed(r_a) < $signed(r_b)));
                    default: wd0 = DATA_W'(!($signed(r_b) < $signed(r_a)));
                endcase
            end
            OP_INVR, OP_NEGA: begin
                we0 = 1'b1;
                wa0 = sp_c;
                wd0 = ((op == OP_NEGA) ? DATA_W'(1) : DATA_W'(0)) - r_b;
            end
            OP_DSVF: begin
                if (r_b == '0) begin
                    pc_new = tgt;
                end
                sp_new = spm1;
            end
            OP_DSVS: pc_new = tgt;
            OP_AMEM: sp_new = sp_c + n_c;
            OP_DMEM: sp_new = sp_c - n_c;
            OP_CRVL: begin
                we0    = 1'b1;
                wa0    = sp1;
                wd0    = r_b;
                sp_new = sp1;
            end
            OP_ARMZ: begin
                we0    = 1'b1;
                wa0    = addr_c;
                wd0    = r_b;
                sp_new = spm1;
            end
            OP_IMPR: begin
                pv     = 1'b1;
                pval   = r_b;
                sp_new = spm1;
            end
            OP_ARMI: begin
                if (r_b[DATA_W-1] || (r_b >= DATA_W'(STACK_DEPTH))) begin
                    ex_fault = FLT_RANGE;
                end else begin
                    we0    = 1'b1;
                    wa0    = signed'(CW'(r_b[SW-1:0]));
                    wd0    = r_a;
                    sp_new = spm1;
                end
            end
            OP_CHPR: begin
                we0    = 1'b1;
                wa0    = sp1;
                wd0    = DATA_W'(pc1);
                wr2    = 1'b1;
                sp_new = sp2;
                pc_new = tgt;
            end
            OP_CREN: begin
                we0    = 1'b1;
                wa0    = sp1;
                wd0    = DATA_W'(addr_c);
                sp_new = sp1;
            end
            OP_ENPR: begin
                we0      = 1'b1;
                wa0      = sp1;
                wd0      = DATA_W'(base_c);
                disp_we  = 1'b1;
                disp_val = sp2[BW-1:0];
                sp_new   = sp1;
            end
            OP_ENRT: sp_new = addr_c - CW'(1);
            OP_RTPR: begin
                if (r_b[DATA_W-1] || (r_b > DATA_W'(STACK_DEPTH))) begin
                    ex_fault = FLT_RANGE;
                end else begin
                    disp_we  = 1'b1;
                    disp_val = r_b[BW-1:0];
                    pc_new   = r_a[PC_W-1:0];
                    sp_new   = sp_ret;
                end
            end
            default: ;
        endcase
    end

    assign ex_commit = (r_state == S_EXE) && (ex_fault == FLT_NONE) && !need_md;
    assign md_req    = '{start: (r_state == S_EXE) && need_md, is_div: (op == OP_DIVI)};
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        ram_raddr = (r_state == S_RDA) ? ra[SW-1:0] : rb[SW-1:0];
        ram_we    = 1'b0;
        ram_waddr = wa0[SW-1:0];
        ram_wdata = wd0;
        if (r_state == S_WR2) begin
            ram_we    = 1'b1;
            ram_waddr = r_w2_addr;
            ram_wdata = r_w2_data;
        end else if (r_state == S_MD) begin
            ram_we    = md_done;
            ram_wdata = md_res;
        end else if (ex_commit) begin
            ram_we    = we0;
        end
    end

    psm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psm_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (md_done),
        .o_result (md_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_RDA;
                end
            end
            S_RDA:  n_state = (rf || bad) ? S_OUT : S_RDB;
            S_RDB:  n_state = S_CAPB;
            S_CAPB: n_state = S_EXE;
            S_EXE: begin
                if (ex_fault != FLT_NONE) begin
                    n_state = S_OUT;
                end else if (need_md) begin
                    n_state = S_MD;
                end else if (wr2) begin
                    n_state = S_WR2;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MD:   n_state = md_done ? S_OUT : S_MD;
            S_WR2:  n_state = S_OUT;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '1;
            r_pc <= '0;
            for (int i = 0; i < DISPLAY_DEPTH; i++) begin
                r_disp[i] <= '0;
            end
        end else if (ex_commit || ((r_state == S_MD) && md_done)) begin
            r_sp <= sp_new[SW:0];
            r_pc <= pc_new;
            if (disp_we && ex_commit) begin
                r_disp[disp_idx] <= disp_val;
            end
        end
    end

    // instruction and operand payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= i_cmd;
            r_k   <= i_first_operand;
            r_n   <= i_second_operand;
            r_rd  <= i_read_value;
        end
        if (r_state == S_RDB) begin
            r_a <= ram_rdata;
        end
        if (r_state == S_CAPB) begin
            r_b <= ram_rdata;
        end
        if (r_state == S_EXE) begin
            r_w2_addr <= sp2[SW-1:0];
            r_w2_data <= DATA_W'(r_n);
        end
        if ((r_state == S_RDA) && (rf || bad)) begin
            r_res_pc    <= r_pc;
            r_res_pv    <= 1'b0;
            r_res_pval  <= '0;
            r_res_fault <= bad ? FLT_OPCODE : FLT_RANGE;
        end else if (r_state == S_EXE) begin
            r_res_pc    <= (ex_fault == FLT_NONE) ? pc_new : r_pc;
            r_res_pv    <= (ex_fault == FLT_NONE) && pv;
            r_res_pval  <= (ex_fault == FLT_NONE) ? pval : '0;
            r_res_fault <= ex_fault;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pc    <= r_res_pc;
            r_out_pv    <= r_res_pv;
            r_out_pval  <= r_res_pval;
            r_out_fault <= r_res_fault;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_print_valid = r_out_pv;
    assign o_print_value = r_out_pval;
    assign o_fault       = r_out_fault;

endmodule

/* src/psm_ram.sv */
module psm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/psm_muldiv.sv */
module psm_muldiv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  psm_pkg::t_md_req            i_req,
    input  logic [psm_pkg::DATA_W-1:0]  i_a,
    input  logic [psm_pkg::DATA_W-1:0]  i_b,
    output logic                        o_done,
    output logic [psm_pkg::DATA_W-1:0]  o_result
);
    import psm_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic              r_div;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W-1:0] rem_s;
    logic [DATA_W-1:0] rem_sub;
    logic              rem_ge;

    // partial remainder never reaches the top bit, divisor magnitude is at most 2^63
    always_comb begin
        rem_s   = {r_acc[DATA_W-2:0], r_x[DATA_W-1]};
        rem_ge  = rem_s >= r_y;
        rem_sub = rem_s - r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                if (i_req.is_div) begin
                    r_x <= i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
                    r_y <= i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
                end else begin
                    r_x <= i_a;
                    r_y <= i_b;
                end
            end else if (r_busy) begin
                if (r_div) begin
                    r_acc <= rem_ge ? rem_sub : rem_s;
                    r_x   <= {r_x[DATA_W-2:0], rem_ge};
                end else begin
                    if (r_x[0]) begin
                        r_acc <= r_acc + r_y;
                    end
                    r_x <= r_x >> 1;
                    r_y <= r_y << 1;
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (DATA_W'(0) - r_x) : r_x) : r_acc;

endmodule

/* src/psm_checker.sv */
module psm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic [psm_pkg::CMD_W-1:0]           i_cmd,
    input logic signed [psm_pkg::OPND_W-1:0]   i_first_operand,
    input logic [psm_pkg::NUM_W-1:0]           i_second_operand,
    input logic signed [psm_pkg::OPND_W-1:0]   i_read_value,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [psm_pkg::PC_W-1:0]            o_next_pc,
    input logic                                o_print_valid,
    input logic signed [psm_pkg::DATA_W-1:0]   o_print_value,
    input logic [1:0]                          o_fault
);
    import psm_pkg::*;

    // result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_next_pc)))
        else $error("result beat dropped before accept");

    // one instruction in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while instruction busy");

    // a faulting instruction prints nothing
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_fault != FLT_NONE)) |-> (!o_print_valid && (o_print_value == '0)))
        else $error("print on faulting instruction");

    // no result beat straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind pascal_stack_machine_executor_core psm_checker u_psm_checker (.*);

/* tb/sv/psm_exec_checker.sv */
`timescale 1ns / 100ps

module psm_exec_checker
    import psm_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      o_in_ready,
    input  logic [CMD_W-1:0]          i_cmd,
    input  logic signed [OPND_W-1:0]  i_first_operand,
    input  logic [NUM_W-1:0]          i_second_operand,
    input  logic signed [OPND_W-1:0]  i_read_value,
    input  logic                      o_out_valid,
    input  logic                      i_out_ready,
    input  logic [PC_W-1:0]           o_next_pc,
    input  logic                      o_print_valid,
    input  logic signed [DATA_W-1:0]  o_print_value,
    input  logic [1:0]                o_fault,
    output int                        o_errors,
    output int                        o_pending
);

    localparam int STK_N  = STACK_DEPTH_DEF;
    localparam int DISP_N = DISPLAY_DEPTH_DEF;

    typedef struct {
        logic [PC_W-1:0]   pc;
        logic              pv;
        logic [DATA_W-1:0] val;
        logic [1:0]        flt;
    } t_exec_result;

    logic [DATA_W-1:0] stk [STK_N];
    longint            disp [DISP_N];
    longint            sp;
    int                pc;
    t_exec_result      result_q [$];

    assign o_pending = result_q.size();

    function automatic logic in_stack(longint a);
        return a >= 0 && a < STK_N;
    endfunction

    function automatic logic [DATA_W-1:0] alu(logic [CMD_W-1:0] c, logic [DATA_W-1:0] a,
                                              logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] ua, ub, q;
        ua = a[DATA_W-1] ? -a : a;
        ub = b[DATA_W-1] ? -b : b;
        q  = ua / ub;
        case (c)
            OP_SOMA: return a + b;
            OP_SUBT: return a - b;
            OP_DIVI: return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
            OP_MULT: return a * b;
            OP_CONJ: return DATA_W'(a == 1 && b == 1);
            OP_DISJ: return DATA_W'(a == 1 || b == 1);
            OP_CMME: return DATA_W'($signed(a) < $signed(b));
            OP_CMMA: return DATA_W'($signed(b) < $signed(a));
            OP_CMIG: return DATA_W'(a == b);
            OP_CMDG: return DATA_W'(a != b);
            OP_CMAG: return DATA_W'(!($signed(a) < $signed(b)));
            default: return DATA_W'(!($signed(b) < $signed(a)));
        endcase
    endfunction

    task automatic execute(input logic [CMD_W-1:0] c, input logic signed [OPND_W-1:0] k,
                           input logic [NUM_W-1:0] n_in, input logic signed [OPND_W-1:0] rv,
                           output t_exec_result r);
        logic [DATA_W-1:0] kx, a, b, p, fb;
        longint            lvl, n, base, addr, s;
        int                nxt, tgt;
        logic [1:0]        f;
        logic              pv, lok;
        logic [DATA_W-1:0] pval;
        kx   = {{(DATA_W-OPND_W){k[OPND_W-1]}}, k};
        lvl  = k[OPND_W-1] ? -1 : longint'(k);
        n    = n_in;
        tgt  = k[PC_W-1:0];
        s    = sp;
        nxt  = (pc + 1) % PROGRAM_SIZE;
        f    = FLT_NONE;
        pv   = 1'b0;
        pval = '0;
        lok  = lvl >= 0 && lvl < DISP_N;
        base = lok ? disp[lvl] : 0;
        addr = base + n;
        case (c)
            OP_INPP: begin
                s = -1;
                disp[0] = 0;
            end
            OP_CRCT, OP_LEIT: begin
                if (!in_stack(s + 1)) f = FLT_RANGE;
                else begin
                    stk[s+1] = (c == OP_CRCT) ? kx : {{(DATA_W-OPND_W){rv[OPND_W-1]}}, rv};
                    s++;
                end
            end
            OP_SOMA, OP_SUBT, OP_DIVI, OP_MULT, OP_CONJ, OP_DISJ,
            OP_CMME, OP_CMMA, OP_CMIG, OP_CMDG, OP_CMAG, OP_CMEG: begin
                if (s < 1 || !in_stack(s)) f = FLT_RANGE;
                else begin
                    a = stk[s-1];
                    b = stk[s];
                    if (c == OP_DIVI && b == 0) f = FLT_DIV0;
                    else begin
                        stk[s-1] = alu(c, a, b);
                        s--;
                    end
                end
            end
            OP_INVR, OP_NEGA: begin
                if (!in_stack(s)) f = FLT_RANGE;
                else stk[s] = ((c == OP_INVR) ? DATA_W'(0) : DATA_W'(1)) - stk[s];
            end
            OP_DSVF: begin
                if (!in_stack(s)) f = FLT_RANGE;
                else begin
                    if (stk[s] == 0) nxt = tgt;
                    s--;
                end
            end
            OP_DSVS: nxt = tgt;
            OP_AMEM: begin
                if (s + n > STK_N - 1) f = FLT_RANGE;
                else s += n;
            end
            OP_DMEM: begin
                if (s - n < -1) f = FLT_RANGE;
                else s -= n;
            end
            OP_CRVL: begin
                if (!lok || !in_stack(addr) || !in_stack(s + 1)) f = FLT_RANGE;
                else begin
                    stk[s+1] = stk[addr];
                    s++;
                end
            end
            OP_ARMZ: begin
                if (!lok || !in_stack(addr) || !in_stack(s)) f = FLT_RANGE;
                else begin
                    stk[addr] = stk[s];
                    s--;
                end
            end
            OP_IMPR: begin
                if (!in_stack(s)) f = FLT_RANGE;
                else begin
                    pv   = 1'b1;
                    pval = stk[s];
                    s--;
                end
            end
            OP_ARMI: begin
                if (!lok || !in_stack(addr) || !in_stack(s)) f = FLT_RANGE;
                else begin
                    p = stk[addr];
                    if (p[DATA_W-1] || p >= STK_N) f = FLT_RANGE;
                    else begin
                        stk[p] = stk[s];
                        s--;
                    end
                end
            end
            OP_CHPR: begin
                if (s + 2 > STK_N - 1 || s + 1 < 0) f = FLT_RANGE;
                else begin
                    stk[s+1] = DATA_W'(nxt);
                    stk[s+2] = DATA_W'(n);
                    s += 2;
                    nxt = tgt;
                end
            end
            OP_CREN: begin
                if (!lok || !in_stack(s + 1)) f = FLT_RANGE;
                else begin
                    stk[s+1] = DATA_W'(addr);
                    s++;
                end
            end
            OP_ENPR: begin
                if (!lok || !in_stack(s + 1)) f = FLT_RANGE;
                else begin
                    stk[s+1] = DATA_W'(base);
                    disp[lvl] = s + 2;
                    s++;
                end
            end
            OP_ENRT: begin
                if (!lok || addr - 1 < -1 || addr - 1 > STK_N - 1) f = FLT_RANGE;
                else s = addr - 1;
            end
            OP_RTPR: begin
                if (!lok || s < 2 || !in_stack(s)) f = FLT_RANGE;
                else begin
                    fb = stk[s];
                    if (fb[DATA_W-1] || fb > STK_N || s - (n + 3) < -1) f = FLT_RANGE;
                    else begin
                        disp[lvl] = longint'(fb);
                        nxt = stk[s-2][PC_W-1:0];
                        s -= n + 3;
                    end
                end
            end
            default: f = FLT_OPCODE;
        endcase
        if (f != FLT_NONE) begin
            nxt  = pc;
            pv   = 1'b0;
            pval = '0;
        end else begin
            sp = s;
            pc = nxt;
        end
        r.pc  = nxt[PC_W-1:0];
        r.pv  = pv;
        r.val = pval;
        r.flt = f;
    endtask

    always @(posedge i_clk) begin
        t_exec_result r, e;
        if (!i_rst_n) begin
            sp = -1;
            pc = 0;
            foreach (disp[i]) disp[i] = 0;
            result_q.delete();
            o_errors = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                execute(i_cmd, i_first_operand, i_second_operand, i_read_value, r);
                result_q.push_back(r);
            end
            if (o_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, pc %0d", $time, o_next_pc);
                    o_errors++;
                end else begin
                    e = result_q.pop_front();
                    if (o_next_pc !== e.pc) begin
                        $display("%0t: next_pc expected %0d actual %0d", $time, e.pc, o_next_pc);
                        o_errors++;
                    end
                    if (o_print_valid !== e.pv) begin
                        $display("%0t: print_valid expected %0b actual %0b",
                                 $time, e.pv, o_print_valid);
                        o_errors++;
                    end
                    if (o_print_value !== e.val) begin
                        $display("%0t: print_value expected %0d actual %0d",
                                 $time, $signed(e.val), o_print_value);
                        o_errors++;
                    end
                    if (o_fault !== e.flt) begin
                        $display("%0t: fault expected %0d actual %0d", $time, e.flt, o_fault);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/tb_pascal_stack_machine_executor_core.sv */
`timescale 1ns / 100ps

module tb_pascal_stack_machine_executor_core;
    import psm_pkg::*;

    localparam int             IDLE_LIMIT = 2000;
    localparam int             NUM_RANDOM = 420;
    localparam logic [CMD_W-1:0] OP_BAD_LO = 5'd30;
    localparam logic [CMD_W-1:0] OP_BAD_HI = 5'd31;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic signed [OPND_W-1:0] i_first_operand = '0;
    logic [NUM_W-1:0]         i_second_operand = '0;
    logic signed [OPND_W-1:0] i_read_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [PC_W-1:0]          o_next_pc;
    logic                     o_print_valid;
    logic signed [DATA_W-1:0] o_print_value;
    logic [1:0]               o_fault;
    int                       n_errors, n_pending;
    int                       n_sent = 0;
    int                       burst_left = 0;
    int                       idle_cycles = 0;
    int                       rcv_run = 0;
    int                       rcv_mode = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pascal_stack_machine_executor_core i_dut (.*);

    psm_exec_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_cmd, .i_first_operand,
        .i_second_operand, .i_read_value, .o_out_valid, .i_out_ready, .o_next_pc,
        .o_print_valid, .o_print_value, .o_fault,
        .o_errors(n_errors), .o_pending(n_pending)
    );

    // receiver: runs of always ready, full stall, or flicker
    always @(posedge i_clk) begin
        if (rcv_run == 0) begin
            rcv_run  = $urandom_range(1, 30);
            rcv_mode = $urandom_range(0, 2);
        end
        rcv_run--;
        case (rcv_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'b0;
            default: i_out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send(input logic [CMD_W-1:0] c, input logic signed [OPND_W-1:0] k,
                        input logic [NUM_W-1:0] n, input logic signed [OPND_W-1:0] rv);
        i_in_valid       <= 1'b1;
        i_cmd            <= c;
        i_first_operand  <= k;
        i_second_operand <= n;
        i_read_value     <= rv;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 1)) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [CMD_W-1:0]         c;
        logic signed [OPND_W-1:0] k, rv;
        logic [NUM_W-1:0]         n;
        int                       r, lv;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // well-formed call frame with random content
            lv = $urandom_range(1, 3);
            send(OP_CHPR, $urandom, NUM_W'(lv), $urandom);
            send(OP_ENPR, lv, 0, 0);
            send(OP_AMEM, 0, NUM_W'($urandom_range(0, 3)), 0);
            send(OP_CRCT, $urandom_range(0, 9), 0, 0);
            send(OP_ARMZ, lv, NUM_W'($urandom_range(0, 2)), 0);
            send(OP_CRVL, lv, NUM_W'($urandom_range(0, 2)), 0);
            send(OP_IMPR, 0, 0, 0);
            send(OP_ENRT, lv, NUM_W'($urandom_range(0, 3)), 0);
            send(OP_RTPR, lv, NUM_W'($urandom_range(0, 3)), 0);
            return;
        end
        if (r < 12)      c = CMD_W'($urandom_range(0, 31));
        else if (r < 15) c = OP_INPP;
        else if (r < 35) c = OP_CRCT;
        else             c = CMD_W'($urandom_range(1, 29));
        r = $urandom_range(0, 9);
        if (r < 6)       k = $urandom_range(0, 4);
        else if (r < 7)  k = -1;
        else if (r < 8)  k = $urandom_range(0, 20);
        else             k = $urandom;
        r = $urandom_range(0, 9);
        if (r < 7)       n = NUM_W'($urandom_range(0, 6));
        else if (r < 9)  n = NUM_W'($urandom_range(0, 40));
        else             n = NUM_W'($urandom);
        rv = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
        send(c, k, n, rv);
    endtask

    initial begin
        logic [CMD_W-1:0] c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // write every stack cell once, then empty the stack
        send(OP_INPP, 0, 0, 0);
        repeat (STACK_DEPTH_DEF) send(OP_CRCT, $urandom, NUM_W'($urandom), $urandom);
        send(OP_CRCT, 1, 0, 0);
        send(OP_DMEM, 0, 10'd1023, 0);
        send(OP_DMEM, 0, 1, 0);
        send(OP_DMEM, 0, 1, 0);

        // extremes, division by minus one, divide by zero, bad opcodes
        send(OP_CRCT, 32'sh7fffffff, 0, 0);
        send(OP_LEIT, 0, 0, 32'sh80000000);
        send(OP_SOMA, 0, 0, 0);
        send(OP_CRCT, 32'sh80000000, 0, 0);
        send(OP_MULT, 0, 0, 0);
        send(OP_CRCT, 2, 0, 0);
        send(OP_MULT, 0, 0, 0);
        send(OP_CRCT, -1, 0, 0);
        send(OP_DIVI, 0, 0, 0);
        send(OP_CRCT, 0, 0, 0);
        send(OP_DIVI, 0, 0, 0);
        send(OP_IMPR, 0, 0, 0);
        send(OP_IMPR, 0, 0, 0);
        send(OP_IMPR, 0, 0, 0);
        send(OP_BAD_LO, 0, 0, 0);
        send(OP_BAD_HI, -1, 10'd1023, -1);
        send(OP_DSVS, 32'shffffffff, 0, 0);
        send(OP_CHPR, 100, 1, 0);
        send(OP_ENPR, 1, 0, 0);
        send(OP_CREN, 1, 5, 0);
        send(OP_ARMI, 1, 0, 0);
        send(OP_RTPR, 1, 0, 0);
        drain();

        // every opcode once over a fresh pair
        for (int op = 2; op <= 29; op++) begin
            c = CMD_W'(op);
            send(OP_CRCT, $urandom_range(0, 2), 0, 0);
            send(OP_CRCT, $urandom_range(0, 2), 0, 0);
            send(c, $urandom_range(0, 1), NUM_W'($urandom_range(0, 1)), $urandom);
            send(OP_INPP, 0, 0, 0);
        end

        for (int i = 0; i < NUM_RANDOM; i++) begin
            send_random();
            if (i == NUM_RANDOM / 2) drain();
        end
        drain();
        repeat (100) @(posedge i_clk);

        $display("%0d instruction beats: stack fill, arithmetic edges, faults,", n_sent);
        $display("call and return frames and random programs under random stalls");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
